[sv/button_press_classifier_macros.svh]
// Assertion macros for the button press classifier.
// Used at the end of the top level; expects a clock named clk and reset rst.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bpc_pkg.sv]
// Shared types and constants for the button press classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bpc_pkg;

  typedef logic [2:0] transition_t;

  localparam transition_t TR_NONE    = 3'd0;
  localparam transition_t TR_INVALID = 3'd1;
  localparam transition_t TR_CLOCK   = 3'd2;
  localparam transition_t TR_ARMED   = 3'd3;
  localparam transition_t TR_STARTED = 3'd4;
  localparam transition_t TR_SHORT   = 3'd5;
  localparam transition_t TR_LONG    = 3'd6;
  localparam transition_t TR_FACTORY = 3'd7;

  localparam int DEB_W  = 9;
  localparam int LONG_W = 14;
  localparam int FACT_W = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_DEBOUNCE = 8'd0;
  localparam cfg_index_t REG_LONG     = 8'd1;
  localparam cfg_index_t REG_FACTORY  = 8'd2;

  localparam logic [DEB_W-1:0]  DEB_MIN   = 9'd5;
  localparam logic [DEB_W-1:0]  DEB_MAX   = 9'd500;
  localparam logic [DEB_W-1:0]  DEB_RST   = 9'd20;
  localparam logic [LONG_W-1:0] LONG_MIN  = 14'd1000;
  localparam logic [LONG_W-1:0] LONG_MAX  = 14'd10000;
  localparam logic [LONG_W-1:0] LONG_RST  = 14'd2000;
  localparam logic [FACT_W-1:0] FACT_MIN  = 15'd5000;
  localparam logic [FACT_W-1:0] FACT_MAX  = 15'd30000;
  localparam logic [FACT_W-1:0] FACT_RST  = 15'd10000;

  typedef struct packed {
    logic [DEB_W-1:0]  deb;
    logic [LONG_W-1:0] lng;
    logic [FACT_W-1:0] fct;
    logic              ok;
  } cfg_bus_t;

  typedef struct packed {
    logic armed;
    logic press_active;
  } bpc_status_t;

endpackage

[sv/button_press_classifier.sv]
// Top level of the button press classifier: sample register, result register,
// configuration port. Depends on bpc_pkg, bpc_config, bpc_core and the macro header.
`timescale 1ns / 1ps
`include "button_press_classifier_macros.svh"

// Debounces timestamped button samples and classifies each armed press on
// release as short, long or factory reset; every accepted sample yields exactly
// one result. One sample is taken per clock while the result is not stalled:
// the sample lands in an input register, the tracking state and classification
// are evaluated from it and committed when the output can advance, and the
// result sits in an output register. The single-step state update (64-bit
// timestamp compares and subtractions) sets that rate. While a result stalls,
// the sample register takes one more sample and then holds off the input.
// Configuration writes clear all tracking state; the validity check of the
// settings is registered from the updated settings registers.

module button_press_classifier import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           now_ms,
  input  logic                  btn_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output transition_t           transition,
  output logic [31:0]           hold_ms,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        s_valid;
  logic [63:0] s_now;
  logic        s_lvl;
  logic        advance;
  logic        step;
  logic        in_fire;
  logic        cfg_fire;
  cfg_bus_t    cfg;
  logic        clear;
  transition_t res_transition;
  logic [31:0] res_hold;
  bpc_status_t status;
  logic        res_release;
  logic        res_has_hold;
  logic        tracking_idle;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign advance   = !out_valid || out_ready;
  assign step      = s_valid && advance;
  assign in_ready  = !s_valid || advance;
  assign in_fire   = in_valid && in_ready;

  bpc_config u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_fire),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .clear    (clear)
  );

  bpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .step       (step),
    .now_ms     (s_now),
    .btn_level  (s_lvl),
    .cfg        (cfg),
    .transition (res_transition),
    .hold_ms    (res_hold),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_fire) begin
      s_valid <= 1'b1;
    end else if (step) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_now <= now_ms;
      s_lvl <= btn_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s_valid;
    end
  end

  // hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (step) begin
      transition <= res_transition;
      hold_ms    <= res_hold;
    end
  end

  assign res_release   = (transition == TR_SHORT) || (transition == TR_LONG) ||
                         (transition == TR_FACTORY);
  assign res_has_hold  = out_valid && (hold_ms != 32'd0);
  assign tracking_idle = !status.press_active && !status.armed;

  `BPC_ASSERT_NOW(a_hold_only_on_release, res_has_hold, res_release, "hold on non-release")
  `BPC_ASSERT_NOW(a_press_not_armed, status.press_active, !status.armed, "press while armed")
  `BPC_ASSERT_NEXT(a_clear_on_write, clear, tracking_idle, "write left tracking state")
  `BPC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled while empty")

endmodule

[sv/bpc_config.sv]
// Configuration registers and the registered validity check.
// Depends on bpc_pkg; drives the config bus and the tracking clear pulse.
`timescale 1ns / 1ps

module bpc_config import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  cfg_index_t            wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_bus_t              cfg,
  output logic                  clear
);

  logic [DEB_W-1:0]  deb;
  logic [LONG_W-1:0] lng;
  logic [FACT_W-1:0] fct;
  logic              ok;
  logic              ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      deb <= DEB_RST;
      lng <= LONG_RST;
      fct <= FACT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE: deb <= wr_data[DEB_W-1:0];
        REG_LONG:     lng <= wr_data[LONG_W-1:0];
        REG_FACTORY:  fct <= wr_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ok_next = (deb >= DEB_MIN) && (deb <= DEB_MAX) &&
              (lng >= LONG_MIN) && (lng <= LONG_MAX) &&
              (fct >= FACT_MIN) && (fct <= FACT_MAX) &&
              (lng > {{(LONG_W-DEB_W){1'b0}}, deb}) &&
              (fct > {{(FACT_W-LONG_W){1'b0}}, lng});
  end

  // reset values form a valid set
  always_ff @(posedge clk) begin
    if (rst) begin
      ok <= 1'b1;
    end else begin
      ok <= ok_next;
    end
  end

  assign clear = wr_en && ((wr_index == REG_DEBOUNCE) || (wr_index == REG_LONG) ||
                           (wr_index == REG_FACTORY));

  assign cfg.deb = deb;
  assign cfg.lng = lng;
  assign cfg.fct = fct;
  assign cfg.ok  = ok;

endmodule

[sv/bpc_core.sv]
// Tracking state and per-sample classification for the button press classifier.
// Depends on bpc_pkg; one sample is evaluated and committed per step.
`timescale 1ns / 1ps

module bpc_core import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        step,
  input  logic [63:0] now_ms,
  input  logic        btn_level,
  input  cfg_bus_t    cfg,
  output transition_t transition,
  output logic [31:0] hold_ms,
  output bpc_status_t status
);

  logic        raw_seen, raw_seen_next;
  logic        raw_level, raw_level_next;
  logic [63:0] raw_change_time, raw_change_time_next;
  logic [63:0] last_sample_time, last_sample_time_next;
  logic        stable_valid, stable_valid_next;
  logic        stable_level, stable_level_next;
  logic        armed_flag, armed_flag_next;
  logic        press_active, press_active_next;
  logic [63:0] press_start_time, press_start_time_next;

  logic        went_back;
  logic        level_change;
  logic [63:0] held_diff;
  logic        held_ge;
  logic [64:0] hold_diff;
  logic [63:0] hold_val;
  logic        fact_hit;
  logic        long_hit;
  logic [31:0] hold_sat;

  always_comb begin
    went_back    = now_ms < last_sample_time;
    level_change = btn_level != raw_level;
    held_diff    = now_ms - raw_change_time;
    // a fresh edge has held for zero ms
    held_ge      = !level_change && (held_diff >= {{(64-DEB_W){1'b0}}, cfg.deb});
    hold_diff    = {1'b0, raw_change_time} - {1'b0, press_start_time};
    hold_val     = hold_diff[64] ? 64'd0 : hold_diff[63:0];
    fact_hit     = (|hold_val[63:FACT_W]) || (hold_val[FACT_W-1:0] >= cfg.fct);
    long_hit     = (|hold_val[63:LONG_W]) || (hold_val[LONG_W-1:0] >= cfg.lng);
    hold_sat     = (|hold_val[63:32]) ? 32'hFFFF_FFFF : hold_val[31:0];
  end

  always_comb begin
    raw_seen_next         = raw_seen;
    raw_level_next        = raw_level;
    raw_change_time_next  = raw_change_time;
    last_sample_time_next = last_sample_time;
    stable_valid_next     = stable_valid;
    stable_level_next     = stable_level;
    armed_flag_next       = armed_flag;
    press_active_next     = press_active;
    press_start_time_next = press_start_time;
    transition            = TR_NONE;
    hold_ms               = 32'd0;

    if (!cfg.ok) begin
      transition = TR_INVALID;
    end else if (!raw_seen || went_back) begin
      // restart tracking at this sample
      raw_seen_next         = 1'b1;
      raw_level_next        = btn_level;
      raw_change_time_next  = now_ms;
      last_sample_time_next = now_ms;
      stable_valid_next     = 1'b0;
      stable_level_next     = 1'b0;
      armed_flag_next       = 1'b0;
      press_active_next     = 1'b0;
      press_start_time_next = 64'd0;
      transition            = raw_seen ? TR_CLOCK : TR_NONE;
    end else begin
      last_sample_time_next = now_ms;
      if (level_change) begin
        raw_level_next       = btn_level;
        raw_change_time_next = now_ms;
      end
      if (!stable_valid) begin
        if (held_ge) begin
          stable_valid_next = 1'b1;
          stable_level_next = raw_level;
          if (!raw_level) begin
            armed_flag_next = 1'b1;
            transition      = TR_ARMED;
          end
        end
      end else if ((raw_level != stable_level) && held_ge) begin
        stable_level_next = raw_level;
        if (raw_level) begin
          if (armed_flag) begin
            armed_flag_next       = 1'b0;
            press_active_next     = 1'b1;
            press_start_time_next = now_ms;
            transition            = TR_STARTED;
          end
        end else begin
          armed_flag_next       = 1'b1;
          press_active_next     = 1'b0;
          press_start_time_next = 64'd0;
          if (!press_active) begin
            transition = TR_ARMED;
          end else begin
            hold_ms = hold_sat;
            priority if (fact_hit) begin
              transition = TR_FACTORY;
            end else if (long_hit) begin
              transition = TR_LONG;
            end else begin
              transition = TR_SHORT;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      raw_seen         <= 1'b0;
      raw_level        <= 1'b0;
      raw_change_time  <= 64'd0;
      last_sample_time <= 64'd0;
      stable_valid     <= 1'b0;
      stable_level     <= 1'b0;
      armed_flag       <= 1'b0;
      press_active     <= 1'b0;
      press_start_time <= 64'd0;
    end else if (step) begin
      raw_seen         <= raw_seen_next;
      raw_level        <= raw_level_next;
      raw_change_time  <= raw_change_time_next;
      last_sample_time <= last_sample_time_next;
      stable_valid     <= stable_valid_next;
      stable_level     <= stable_level_next;
      armed_flag       <= armed_flag_next;
      press_active     <= press_active_next;
      press_start_time <= press_start_time_next;
    end
  end

  assign status.armed        = armed_flag;
  assign status.press_active = press_active;

endmodule
